// File: rtl/lphm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the linear-probing hash map.
package lphm_pkg;

	// Default number of slots and the reset value of the load limit.
	localparam int CAPACITY_DEFAULT = 64;
	localparam logic [6:0] LOAD_LIMIT_RESET = 7'd51;

	// Fixed field widths.
	localparam int KEY_W   = 64;
	localparam int DATA_W  = 64;
	localparam int LIMIT_W = 7;
	localparam int LIVE_W  = 7;

	// Operation codes carried by func.
	typedef enum logic [1:0] {
		FUNC_SET    = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// Slot marks.
	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	// One table slot as stored in the slot memory.
	typedef struct packed {
		mark_t             mark;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} slot_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_UPDATE,
		ST_RESP
	} state_t;

endpackage

// File: rtl/lphm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lphm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/lphm_hash.sv
`timescale 1ns / 1ps
// Home slot unit: folds a key to 32 bits and reduces it modulo the capacity.
module lphm_hash #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lphm_pkg::KEY_W-1:0]   key,
	output logic                         done,
	output logic [$clog2(CAPACITY)-1:0]  slot
);

	localparam int IW = $clog2(CAPACITY);
	localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

	logic [31:0] fold;

	assign fold = key[31:0] ^ key[63:32];

	generate
		if (POW2) begin : g_mask
			// Power-of-two capacity: the remainder is the low bits.
			logic [IW-1:0] slot_q;
			logic          done_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					slot_q <= fold[IW-1:0];
				end
			end

			assign done = done_q;
			assign slot = slot_q;
		end else begin : g_recip
			// Other capacities: multiplying by the truncated reciprocal gives a
			// quotient that is low by at most one, so after the back multiply
			// and subtract one compare and subtract finishes the remainder.
			localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(CAPACITY);
			localparam logic [31:0] RECIP   = RECIP_W[31:0];
			localparam logic [31:0] CAP_32  = 32'(CAPACITY);
			localparam logic [IW:0] CAP_W   = (IW + 1)'(CAPACITY);

			logic [31:0]   h_q;
			logic [63:0]   prod_q;
			logic [IW:0]   rem_q;
			logic          mul_q;
			logic          sub_q;
			logic          done_q;
			logic [31:0]   qc;
			logic [31:0]   diff;
			logic [IW:0]   rem_fix;

			// Back multiply, subtract and the final correction.
			always_comb begin
				qc      = prod_q[63:32] * CAP_32;
				diff    = h_q - qc;
				rem_fix = (rem_q >= CAP_W) ? (rem_q - CAP_W) : rem_q;
			end

			// Step flags: folded key held, product held, remainder held.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mul_q  <= 1'b0;
					sub_q  <= 1'b0;
					done_q <= 1'b0;
				end else begin
					mul_q  <= start;
					sub_q  <= mul_q;
					done_q <= sub_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					h_q <= fold;
				end
				if (mul_q) begin
					prod_q <= 64'(h_q) * 64'(RECIP);
				end
				if (sub_q) begin
					rem_q <= diff[IW:0];
				end
			end

			assign done = done_q;
			assign slot = rem_fix[IW-1:0];
		end
	endgenerate

endmodule

// File: rtl/linear_probe_hash_map.sv
`timescale 1ns / 1ps
// Top level of the linear-probing hash map: sequencer, slot memory and result register.
//
// Usage: an operation beat (func, key, value) enters on in_valid/in_ready and
// one result beat (found, value_out, status, live_count) leaves on
// out_valid/out_ready for every operation. func selects set, get, remove or
// clear. The load limit is written through cfg_we/cfg_wdata while idle.
// One operation is handled at a time; in_ready is high only while idle.
// Set, get and remove pass through the hash, probe, update and result
// states, the probe reading one slot per cycle from the slot memory; the next
// beat can be taken once the sequencer is back in idle. A capacity that is
// not a power of two computes the home slot in registered steps (reciprocal
// multiply, back multiply and subtract), then one correction.
// A clear sweeps every slot before it raises out_valid, and a remove that
// drops the last live entry sweeps the slot memory before its result. After
// reset the same sweep runs before in_ready rises; configuration writes are
// taken throughout.
// Results sit in an output register: a stalled receiver does not stop the
// next operation from being accepted and worked on, but that operation's
// result waits until the held beat is taken.
module linear_probe_hash_map #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_we,
	input  logic [lphm_pkg::LIMIT_W-1:0]  cfg_wdata,
	// Operation channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [lphm_pkg::KEY_W-1:0]    key,
	input  logic [lphm_pkg::DATA_W-1:0]   value,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [lphm_pkg::DATA_W-1:0]   value_out,
	output logic                          status,
	output logic [lphm_pkg::LIVE_W-1:0]   live_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > lphm_pkg::LIMIT_W) ? CW : lphm_pkg::LIMIT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	lphm_pkg::state_t st_q, st_d;

	// Control registers
	logic [lphm_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0]                count_q;
	logic [IW-1:0]                clr_idx_q;
	logic                         pend_q;
	logic                         out_valid_q;

	// Item registers
	lphm_pkg::func_t              func_q;
	logic [lphm_pkg::KEY_W-1:0]   key_q;
	logic [lphm_pkg::DATA_W-1:0]  value_q;
	logic [IW-1:0]                idx_q;
	logic [CW-1:0]                n_q;
	logic                         hit_q;
	logic [lphm_pkg::DATA_W-1:0]  hit_data_q;
	logic                         free_valid_q;
	logic [IW-1:0]                free_idx_q;
	logic                         found_r_q;
	logic [lphm_pkg::DATA_W-1:0]  vout_r_q;
	logic                         status_r_q;

	// Output registers
	logic                         found_q;
	logic [lphm_pkg::DATA_W-1:0]  value_out_q;
	logic                         status_q;
	logic [lphm_pkg::LIVE_W-1:0]  live_q;

	// Slot memory and hash unit signals
	logic                         ram_we;
	logic [IW-1:0]                ram_waddr;
	lphm_pkg::slot_t              ram_wdata;
	logic [IW-1:0]                ram_raddr;
	lphm_pkg::slot_t              ram_rdata;
	logic                         hash_start;
	logic                         hash_done;
	logic [IW-1:0]                hash_slot;

	// Probe and limit decisions
	logic [IW-1:0]                idx_inc;
	logic [CW-1:0]                n_next;
	logic                         hit_now;
	logic                         stop_now;
	logic [LW-1:0]                limit_eff;
	logic                         full;
	logic                         accept;
	logic                         resp_load;

	lphm_hash #(
		.CAPACITY(CAPACITY)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	lphm_ram #(
		.WIDTH($bits(lphm_pkg::slot_t)),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Probe step: the read data belongs to slot idx_q.
	always_comb begin
		idx_inc   = (idx_q == LAST_IDX) ? '0 : (idx_q + 1'b1);
		n_next    = n_q + 1'b1;
		hit_now   = (ram_rdata.mark == lphm_pkg::MARK_USED) && (ram_rdata.key == key_q);
		stop_now  = (ram_rdata.mark == lphm_pkg::MARK_EMPTY) || (n_next == CAP_C);
		limit_eff = (LW'(limit_q) > CAP_L) ? CAP_L : LW'(limit_q);
		full      = (LW'(count_q) >= limit_eff) || !free_valid_q;
	end

	// Next state and memory control.
	always_comb begin
		st_d       = st_q;
		in_ready   = 1'b0;
		hash_start = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata      = '0;
		ram_wdata.mark = lphm_pkg::MARK_USED;
		ram_wdata.key  = key_q;
		ram_wdata.data = value_q;
		ram_raddr  = idx_inc;
		unique case (st_q)
			lphm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
				if (clr_idx_q == LAST_IDX) begin
					st_d = pend_q ? lphm_pkg::ST_RESP : lphm_pkg::ST_IDLE;
				end
			end
			lphm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == lphm_pkg::FUNC_CLEAR) begin
						st_d = lphm_pkg::ST_CLEAR;
					end else begin
						hash_start = 1'b1;
						st_d       = lphm_pkg::ST_HASH;
					end
				end
			end
			lphm_pkg::ST_HASH: begin
				ram_raddr = hash_slot;
				if (hash_done) begin
					st_d = lphm_pkg::ST_PROBE;
				end
			end
			lphm_pkg::ST_PROBE: begin
				if (hit_now || stop_now) begin
					st_d = lphm_pkg::ST_UPDATE;
				end
			end
			lphm_pkg::ST_UPDATE: begin
				st_d = lphm_pkg::ST_RESP;
				case (func_q)
					lphm_pkg::FUNC_SET: begin
						if (hit_q) begin
							ram_we = 1'b1;
						end else if (!full) begin
							ram_we    = 1'b1;
							ram_waddr = free_idx_q;
						end
					end
					lphm_pkg::FUNC_REMOVE: begin
						if (hit_q) begin
							ram_we         = 1'b1;
							ram_wdata.mark = lphm_pkg::MARK_TOMB;
							if (count_q == CW'(1)) begin
								st_d = lphm_pkg::ST_CLEAR;
							end
						end
					end
					default: begin
					end
				endcase
			end
			lphm_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					st_d = lphm_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = lphm_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign resp_load = (st_q == lphm_pkg::ST_RESP) && (st_d == lphm_pkg::ST_IDLE);

	// Sequencer state, load limit, entry count, sweep pointer, pending flag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lphm_pkg::ST_CLEAR;
			limit_q     <= lphm_pkg::LOAD_LIMIT_RESET;
			count_q     <= '0;
			clr_idx_q   <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				pend_q <= 1'b1;
			end
			if (st_q == lphm_pkg::ST_CLEAR) begin
				count_q   <= '0;
				clr_idx_q <= (clr_idx_q == LAST_IDX) ? '0 : (clr_idx_q + 1'b1);
			end
			if (st_q == lphm_pkg::ST_UPDATE) begin
				if (func_q == lphm_pkg::FUNC_SET && !hit_q && !full) begin
					count_q <= count_q + 1'b1;
				end else if (func_q == lphm_pkg::FUNC_REMOVE && hit_q) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, probe tracking and result formation.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= lphm_pkg::func_t'(func);
			key_q        <= key;
			value_q      <= value;
			hit_q        <= 1'b0;
			free_valid_q <= 1'b0;
			found_r_q    <= 1'b0;
			vout_r_q     <= '0;
			status_r_q   <= 1'b0;
		end
		if (st_q == lphm_pkg::ST_HASH && hash_done) begin
			idx_q <= hash_slot;
			n_q   <= '0;
		end
		if (st_q == lphm_pkg::ST_PROBE) begin
			if (hit_now) begin
				hit_q      <= 1'b1;
				hit_data_q <= ram_rdata.data;
			end else begin
				// Remember the first tombstone or empty slot of the chain.
				if (ram_rdata.mark != lphm_pkg::MARK_USED && !free_valid_q) begin
					free_valid_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				if (!stop_now) begin
					idx_q <= idx_inc;
					n_q   <= n_next;
				end
			end
		end
		if (st_q == lphm_pkg::ST_UPDATE) begin
			found_r_q <= hit_q;
			if (func_q == lphm_pkg::FUNC_SET) begin
				status_r_q <= !hit_q && full;
			end else begin
				vout_r_q <= hit_q ? hit_data_q : '0;
			end
		end
		if (resp_load) begin
			found_q     <= found_r_q;
			value_out_q <= vout_r_q;
			status_q    <= status_r_q;
			live_q      <= lphm_pkg::LIVE_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign value_out  = value_out_q;
	assign status     = status_q;
	assign live_count = live_q;

	// The live entry count never exceeds the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// Only one operation is in flight: no accept right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("operation accepted while another is in flight");

	// Only a set can be rejected at the load limit.
	a_status_set_only: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lphm_pkg::ST_UPDATE && func_q != lphm_pkg::FUNC_SET) |=> !status_r_q)
		else $error("reject status on an operation other than set");

	// A successful remove drops the count by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lphm_pkg::ST_UPDATE && func_q == lphm_pkg::FUNC_REMOVE && hit_q)
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not decrement the entry count");

endmodule

// File: verif/tb_linear_probe_hash_map.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probing hash map with a built-in table predictor.
module tb_linear_probe_hash_map;
	import lphm_pkg::*;

	localparam int CAP = CAPACITY_DEFAULT;
	localparam logic [31:0] CAP_U = CAP;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_SIZE = 96;

	typedef struct {
		func_t       func;
		logic [63:0] key;
		logic [63:0] value;
	} op_item_t;

	typedef struct {
		logic        found;
		logic [63:0] value_out;
		logic        status;
		logic [6:0]  live_count;
	} map_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [63:0] key = '0;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [63:0] value_out;
	logic        status;
	logic [6:0]  live_count;

	// Pending operations for the driver and results still owed by the block.
	op_item_t    pending_ops[$];
	map_result_t owed_results[$];

	// Shadow copy of the table.
	logic [63:0] tbl_key[CAP];
	logic [63:0] tbl_data[CAP];
	mark_t       tbl_mark[CAP];
	int          tbl_count;
	logic [6:0]  tbl_limit;

	logic [63:0] key_pool[POOL_SIZE];

	int unsigned cycles = 0;
	int          accepted_cnt = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          errs = 0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          rx_mode = 0;

	linear_probe_hash_map #(
		.CAPACITY(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.value_out(value_out),
		.status(status),
		.live_count(live_count)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Empty every slot of the shadow table.
	function automatic void wipe_table();
		foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
		tbl_count = 0;
	endfunction

	// Walk the probe chain of k; return the slot holding k or -1, and the
	// first tombstone or empty slot passed on the way.
	function automatic int find_slot(input logic [63:0] k, output int first_free);
		logic [31:0] h;
		int idx;
		int hit;
		h = k[31:0] ^ k[63:32];
		idx = int'(h % CAP_U);
		hit = -1;
		first_free = -1;
		for (int n = 0; n < CAP; n++) begin
			if (tbl_mark[idx] == MARK_USED) begin
				if (tbl_key[idx] == k) begin
					hit = idx;
					break;
				end
			end else begin
				if (first_free < 0) first_free = idx;
				if (tbl_mark[idx] == MARK_EMPTY) break;
			end
			idx = (idx + 1) % CAP;
		end
		return hit;
	endfunction

	// Apply one operation to the shadow table and return the result beat it yields.
	function automatic map_result_t apply_op(input func_t op_code, input logic [63:0] k,
			input logic [63:0] v);
		map_result_t r;
		int hit;
		int free_slot;
		int lim;
		r.found = 1'b0;
		r.value_out = '0;
		r.status = 1'b0;
		lim = (int'(tbl_limit) > CAP) ? CAP : int'(tbl_limit);
		case (op_code)
			FUNC_SET: begin
				hit = find_slot(k, free_slot);
				if (hit >= 0) begin
					r.found = 1'b1;
					tbl_data[hit] = v;
				end else if (tbl_count >= lim || free_slot < 0) begin
					r.status = 1'b1;
				end else begin
					tbl_key[free_slot] = k;
					tbl_data[free_slot] = v;
					tbl_mark[free_slot] = MARK_USED;
					tbl_count++;
				end
			end
			FUNC_GET: begin
				hit = find_slot(k, free_slot);
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value_out = tbl_data[hit];
				end
			end
			FUNC_REMOVE: begin
				hit = find_slot(k, free_slot);
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value_out = tbl_data[hit];
					tbl_mark[hit] = MARK_TOMB;
					if (tbl_count > 0) tbl_count--;
					// Dropping the last live entry also drops all tombstones.
					if (tbl_count == 0) wipe_table();
				end
			end
			default: begin
				wipe_table();
			end
		endcase
		r.live_count = 7'(tbl_count);
		return r;
	endfunction

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Driver: predicts each accepted beat, then offers the next one in bursts with gaps.
	always @(posedge clk) begin : driver
		op_item_t op;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				owed_results.push_back(apply_op(func_t'(func), key, value));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_ops.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					op = pending_ops.pop_front();
					func <= op.func;
					key <= op.key;
					value <= op.value;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Long receiver hold-off once enough beats have gone in, so the block backs up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Monitor: checks each result beat against the oldest prediction and drives out_ready.
	always @(posedge clk) begin : monitor
		map_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("Unexpected result beat: found=%0b value_out=%h status=%0b live=%0d",
							found, value_out, status, live_count);
				end else begin
					want = owed_results.pop_front();
					if (found !== want.found || value_out !== want.value_out ||
							status !== want.status || live_count !== want.live_count) begin
						errs++;
						if (errs <= 10)
							$display("Mismatch: expected found=%0b value_out=%h status=%0b live=%0d, got found=%0b value_out=%h status=%0b live=%0d",
								want.found, want.value_out, want.status, want.live_count,
								found, value_out, status, live_count);
					end
				end
			end
			// The stall pattern is redrawn at regular points of the cycle counter.
			if (cycles % 128 == 0) rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (cycles % 4 == 0);
					default: out_ready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// Queue one operation for the driver.
	task automatic add_op(input func_t f, input logic [63:0] k, input logic [63:0] v);
		op_item_t op;
		op.func = f;
		op.key = k;
		op.value = v;
		pending_ops.push_back(op);
	endtask

	// Queue n random operations drawn mostly from the first span keys of the pool.
	task automatic add_random_ops(input int n, input int span, input int set_pct);
		int r;
		func_t f;
		logic [63:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < set_pct) f = FUNC_SET;
			else if (r < set_pct + (96 - set_pct) / 2) f = FUNC_GET;
			else if (r < 96) f = FUNC_REMOVE;
			else f = FUNC_CLEAR;
			if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, span - 1)];
			else k = {$urandom, $urandom};
			add_op(f, k, {$urandom, $urandom});
		end
	endtask

	// Wait until every queued beat has gone in and every result has come out.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_ops.size() != 0 || in_valid || owed_results.size() != 0);
	endtask

	// Write the load limit while the block is idle.
	task automatic write_limit(input logic [6:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl_limit = lim;
	endtask

	initial begin : main
		logic [31:0] hi;
		logic [5:0] home;
		logic [63:0] ka, kb, kc, kd, ke, kf;
		wipe_table();
		tbl_limit = LOAD_LIMIT_RESET;

		// Key pool crowded onto a few home slots so that chains grow long.
		for (int i = 0; i < POOL_SIZE; i++) begin
			hi = $urandom;
			home = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 11));
			key_pool[i] = {hi, hi ^ {26'($urandom), home}};
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. ka, kb, kc and kd share home slot 0; ke and kf share home slot 63.
		ka = 64'h0;
		kb = '1;
		kc = 64'h00000001_00000001;
		kd = 64'h00000040_00000000;
		ke = 64'hFFFFFFFF_00000000;
		kf = 64'h00000000_0000003F;
		add_op(FUNC_GET, ka, '1);
		add_op(FUNC_REMOVE, ka, '1);
		add_op(FUNC_SET, ka, 64'h0);
		add_op(FUNC_SET, kb, '1);
		add_op(FUNC_SET, kc, 64'h5555_5555_5555_5555);
		add_op(FUNC_GET, kb, 64'h0);
		add_op(FUNC_SET, ka, 64'hAAAA_AAAA_AAAA_AAAA);
		add_op(FUNC_REMOVE, kb, 64'h0);
		// Lookups and updates must walk past the tombstone, not stop on it.
		add_op(FUNC_GET, kc, 64'h0);
		add_op(FUNC_SET, kc, 64'h1234_5678_9ABC_DEF0);
		add_op(FUNC_SET, kd, 64'h0F0F_0F0F_0F0F_0F0F);
		add_op(FUNC_GET, kd, 64'h0);
		add_op(FUNC_GET, kb, 64'h0);
		add_op(FUNC_REMOVE, ka, 64'h0);
		add_op(FUNC_REMOVE, kc, 64'h0);
		add_op(FUNC_REMOVE, kd, 64'h0);
		add_op(FUNC_GET, kc, 64'h0);
		// Chain that wraps from the last slot to the first.
		add_op(FUNC_SET, ke, 64'h1);
		add_op(FUNC_SET, kf, 64'h2);
		add_op(FUNC_GET, kf, 64'h0);
		add_op(FUNC_CLEAR, '1, '1);
		add_op(FUNC_GET, ke, 64'h0);
		add_op(FUNC_SET, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		wait_idle();

		// Tiny limit: most inserts get rejected.
		write_limit(7'd4);
		add_random_ops(60, 8, 55);
		wait_idle();

		// Limit zero: updates of present keys pass, new keys are rejected.
		write_limit(7'd0);
		add_random_ops(30, 8, 70);
		wait_idle();

		// Limit above capacity: fill the whole table, so probes find no empty slot.
		write_limit(7'd127);
		for (int i = 0; i < 80; i++) add_op(FUNC_SET, key_pool[i], {$urandom, $urandom});
		add_random_ops(70, POOL_SIZE, 40);
		wait_idle();

		// Limit equal to capacity.
		write_limit(7'd64);
		add_random_ops(100, POOL_SIZE, 50);
		wait_idle();

		// Lowest useful limit.
		write_limit(7'd1);
		add_random_ops(50, 4, 45);
		wait_idle();

		// Random limit in range.
		write_limit(7'($urandom_range(1, 64)));
		add_random_ops(100, 48, 45);
		wait_idle();

		// Back to the reset limit.
		write_limit(LOAD_LIMIT_RESET);
		add_random_ops(40, 32, 45);
		wait_idle();

		// Let a trailing sweep finish and catch any stray beat.
		repeat (200) @(negedge clk);
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
